// ===== src/aimdwc_pkg.sv =====
// ----------------------------------------------------------------------------
// AIMD window controller package
// Widths, codes, reset values and the shared state, config and result types.
// ----------------------------------------------------------------------------
package aimdwc_pkg;

    // Field widths
    localparam int TIME_BITS    = 48;
    localparam int COUNT_BITS   = 48;
    localparam int WIN_BITS     = 16;
    localparam int FACTOR_BITS  = 16;
    localparam int GAP_BITS     = 32;
    localparam int ERR_BITS     = 32;
    localparam int KIND_BITS    = 2;
    localparam int STATUS_BITS  = 3;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    // Item kinds
    localparam logic [KIND_BITS-1:0] KIND_INCREASE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DECREASE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_ERROR    = 2'd2;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_INCREASED    = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_RATE_LIMITED = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_AT_MAX       = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_DECREASED    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_KEPT         = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_ERROR        = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_DISABLED     = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_WINDOW = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WINDOW     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INCREASE_STEP  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECREASE_FACTOR = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_GAP        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ADJUST_DISABLE = 3'd5;

    // Reset values
    localparam logic [WIN_BITS-1:0]    RST_INITIAL_WINDOW = 16'd5;
    localparam logic [WIN_BITS-1:0]    RST_MAX_WINDOW     = 16'd5;
    localparam logic [WIN_BITS-1:0]    RST_INCREASE_STEP  = 16'd2;
    localparam logic [FACTOR_BITS-1:0] RST_DECREASE_FACTOR = 16'd49152;
    localparam logic [GAP_BITS-1:0]    RST_MIN_GAP        = 32'd500;

    typedef struct packed {
        logic [WIN_BITS-1:0]    max_window;
        logic [WIN_BITS-1:0]    step;
        logic [FACTOR_BITS-1:0] factor;
        logic [GAP_BITS-1:0]    min_gap;
        logic                   disabled;
    } t_cfg;

    typedef struct packed {
        logic [WIN_BITS-1:0]   window;
        logic [TIME_BITS-1:0]  last_inc;
        logic                  ever_inc;
        logic [COUNT_BITS-1:0] prev_ins;
        logic [ERR_BITS-1:0]   prev_err;
        logic [ERR_BITS-1:0]   err_cnt;
    } t_state;

    typedef struct packed {
        logic [WIN_BITS-1:0]    window_s;
        logic [STATUS_BITS-1:0] status;
        logic [ERR_BITS-1:0]    error_total;
    } t_result;

endpackage

// ===== src/aimdwc_if.sv =====
// ----------------------------------------------------------------------------
// AIMD window controller channels
// Valid/ready channels for request items, result items and config writes.
// ----------------------------------------------------------------------------
interface aimdwc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [aimdwc_pkg::KIND_BITS-1:0]       kind;
    logic [aimdwc_pkg::TIME_BITS-1:0]       now_ms;
    logic [aimdwc_pkg::COUNT_BITS-1:0]      insert_count;

    modport source (output valid, kind, now_ms, insert_count, input ready);
    modport sink   (input valid, kind, now_ms, insert_count, output ready);
endinterface

interface aimdwc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [aimdwc_pkg::WIN_BITS-1:0]        window_s;
    logic [aimdwc_pkg::STATUS_BITS-1:0]     status;
    logic [aimdwc_pkg::ERR_BITS-1:0]        error_total;

    modport source (output valid, window_s, status, error_total, input ready);
    modport sink   (input valid, window_s, status, error_total, output ready);
endinterface

interface aimdwc_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [aimdwc_pkg::CFG_IDX_BITS-1:0]    index;
    logic [aimdwc_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/aimdwc_step.sv =====
// ----------------------------------------------------------------------------
// AIMD window controller update step
// Next state and status for one request item, pure combinational logic.
// ----------------------------------------------------------------------------
module aimdwc_step (
    input  aimdwc_pkg::t_cfg                        i_cfg,
    input  aimdwc_pkg::t_state                      i_state,
    input  logic [aimdwc_pkg::KIND_BITS-1:0]        i_kind,
    input  logic [aimdwc_pkg::TIME_BITS-1:0]        i_now_ms,
    input  logic [aimdwc_pkg::COUNT_BITS-1:0]       i_insert_count,
    output aimdwc_pkg::t_state                      o_state,
    output logic [aimdwc_pkg::STATUS_BITS-1:0]      o_status
);

    logic [aimdwc_pkg::TIME_BITS-1:0]   gap;
    logic [aimdwc_pkg::TIME_BITS-1:0]   earliest;
    logic                               too_soon;
    logic [aimdwc_pkg::WIN_BITS:0]      sum;
    logic [aimdwc_pkg::WIN_BITS-1:0]    inc_window;
    logic [2*aimdwc_pkg::WIN_BITS-1:0]  prod;
    logic                               dec_ok;

    // Rate limit after an increase: refuse if now < gap or too near last increase
    assign gap      = aimdwc_pkg::TIME_BITS'(i_cfg.min_gap);
    assign earliest = i_now_ms - gap;
    assign too_soon = i_state.ever_inc && ((i_now_ms < gap) || (i_state.last_inc > earliest));

    // Additive increase, clamped at the maximum
    assign sum        = {1'b0, i_state.window} + {1'b0, i_cfg.step};
    assign inc_window = (sum > {1'b0, i_cfg.max_window}) ? i_cfg.max_window
                                                         : sum[aimdwc_pkg::WIN_BITS-1:0];

    // Multiplicative decrease, Q0.16 factor, product truncated
    assign prod   = {{aimdwc_pkg::FACTOR_BITS{1'b0}}, i_state.window}
                  * {{aimdwc_pkg::WIN_BITS{1'b0}}, i_cfg.factor};
    assign dec_ok = (i_insert_count > i_state.prev_ins) && (i_state.err_cnt == i_state.prev_err);

    always_comb begin
        o_state  = i_state;
        o_status = aimdwc_pkg::ST_KEPT;
        case (i_kind)
            aimdwc_pkg::KIND_ERROR: begin
                o_state.err_cnt = i_state.err_cnt + aimdwc_pkg::ERR_BITS'(1);
                o_status        = aimdwc_pkg::ST_ERROR;
            end
            aimdwc_pkg::KIND_INCREASE: begin
                if (i_cfg.disabled) begin
                    o_status = aimdwc_pkg::ST_DISABLED;
                end else if (too_soon) begin
                    o_status = aimdwc_pkg::ST_RATE_LIMITED;
                end else if (i_state.window == i_cfg.max_window) begin
                    o_status = aimdwc_pkg::ST_AT_MAX;
                end else begin
                    o_state.window   = inc_window;
                    o_state.last_inc = i_now_ms;
                    o_state.ever_inc = 1'b1;
                    o_status         = aimdwc_pkg::ST_INCREASED;
                end
            end
            aimdwc_pkg::KIND_DECREASE: begin
                if (i_cfg.disabled) begin
                    o_status = aimdwc_pkg::ST_DISABLED;
                end else begin
                    if (dec_ok) begin
                        o_state.window = prod[2*aimdwc_pkg::WIN_BITS-1:aimdwc_pkg::WIN_BITS];
                        o_status       = aimdwc_pkg::ST_DECREASED;
                    end
                    // record both counts on every decrease request
                    o_state.prev_ins = i_insert_count;
                    o_state.prev_err = i_state.err_cnt;
                end
            end
            default: begin
                o_status = aimdwc_pkg::ST_KEPT;
            end
        endcase
    end

endmodule

// ===== src/aimd_window_controller_top.sv =====
// ----------------------------------------------------------------------------
// AIMD window controller
// Window in seconds with additive increase and multiplicative decrease.
//
//   Port    Dir   Handshake     Payload
//   i_in    in    valid/ready   kind, now_ms, insert_count
//   o_out   out   valid/ready   window_s, status, error_total
//   i_cfg   in    valid/ready   index, data (always ready)
//
// One item per cycle while i_in.ready is high: the update step is one pass of
// logic between the state registers and the output register, one result per item.
// A two-entry output stage (output register plus skid register) keeps
// i_in.ready a register; it drops only while both entries hold results.
// Reset is synchronous: window goes to 5, counters and config to defaults.
// A write of the initial window register has no effect; reset always loads 5.
// ----------------------------------------------------------------------------
module aimd_window_controller_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    aimdwc_in_if.sink           i_in,
    aimdwc_out_if.source        o_out,
    aimdwc_cfg_if.sink          i_cfg
);

    aimdwc_pkg::t_cfg       r_cfg;
    aimdwc_pkg::t_state     r_state;
    aimdwc_pkg::t_state     n_state;
    logic [aimdwc_pkg::STATUS_BITS-1:0] n_status;
    aimdwc_pkg::t_result    n_result;
    aimdwc_pkg::t_result    r_out;
    aimdwc_pkg::t_result    r_skid;
    logic                   r_out_valid;
    logic                   r_skid_valid;
    logic                   accept;
    logic                   load_out;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;
    assign accept      = i_in.valid && !r_skid_valid;
    assign load_out    = !r_out_valid || o_out.ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_window <= aimdwc_pkg::RST_MAX_WINDOW;
            r_cfg.step       <= aimdwc_pkg::RST_INCREASE_STEP;
            r_cfg.factor     <= aimdwc_pkg::RST_DECREASE_FACTOR;
            r_cfg.min_gap    <= aimdwc_pkg::RST_MIN_GAP;
            r_cfg.disabled   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                aimdwc_pkg::REG_MAX_WINDOW:
                    r_cfg.max_window <= i_cfg.data[aimdwc_pkg::WIN_BITS-1:0];
                aimdwc_pkg::REG_INCREASE_STEP:
                    r_cfg.step <= i_cfg.data[aimdwc_pkg::WIN_BITS-1:0];
                aimdwc_pkg::REG_DECREASE_FACTOR:
                    r_cfg.factor <= i_cfg.data[aimdwc_pkg::FACTOR_BITS-1:0];
                aimdwc_pkg::REG_MIN_GAP:
                    r_cfg.min_gap <= i_cfg.data[aimdwc_pkg::GAP_BITS-1:0];
                aimdwc_pkg::REG_ADJUST_DISABLE:
                    r_cfg.disabled <= i_cfg.data[0];
                default: begin
                    // initial window writes and unused indexes are ignored
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Update step
    aimdwc_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_kind         (i_in.kind),
        .i_now_ms       (i_in.now_ms),
        .i_insert_count (i_in.insert_count),
        .o_state        (n_state),
        .o_status       (n_status)
    );

    assign n_result.window_s    = n_state.window;
    assign n_result.status      = n_status;
    assign n_result.error_total = n_state.err_cnt;

    // Advance state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.window   <= aimdwc_pkg::RST_INITIAL_WINDOW;
            r_state.last_inc <= '0;
            r_state.ever_inc <= 1'b0;
            r_state.prev_ins <= '0;
            r_state.prev_err <= '0;
            r_state.err_cnt  <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Output register and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load_out) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (!load_out && accept) begin
            r_skid <= n_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.window_s    = r_out.window_s;
    assign o_out.status      = r_out.status;
    assign o_out.error_total = r_out.error_total;

    // Checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while output register is empty");

    a_error_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.kind == aimdwc_pkg::KIND_ERROR)
        |=> (r_state.err_cnt == $past(r_state.err_cnt) + aimdwc_pkg::ERR_BITS'(1)))
        else $error("error event not counted");

    a_disabled_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_cfg.disabled && i_in.kind != aimdwc_pkg::KIND_ERROR)
        |=> $stable(r_state.window))
        else $error("window changed while adjustment disabled");

endmodule

// ===== test/aimd_window_controller_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AIMD window controller testbench
// Drives increase, decrease and error items through the request channel,
// predicts each result with an in-bench window model and checks every result
// field by field. Config writes happen only while the block is idle, and
// several settings are used, extremes among them. Both sides idle at random,
// and the receiver holds off twice for a long stretch.
// ----------------------------------------------------------------------------
module aimd_window_controller_top_test;

    localparam int WB = aimdwc_pkg::WIN_BITS;
    localparam int TB = aimdwc_pkg::TIME_BITS;
    localparam int CB = aimdwc_pkg::COUNT_BITS;
    localparam int EB = aimdwc_pkg::ERR_BITS;
    localparam int DB = aimdwc_pkg::CFG_DATA_BITS;

    localparam logic [aimdwc_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned RUN_LIMIT  = 400000;
    localparam int          HOLD_SPAN  = 300;
    localparam int          DRAIN_WAIT = 8;
    localparam int          PRINT_CAP  = 40;

    typedef struct {
        logic [aimdwc_pkg::KIND_BITS-1:0] kind;
        logic [TB-1:0]                    now_ms;
        logic [CB-1:0]                    insert_count;
    } t_window_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    aimdwc_in_if  in_if();
    aimdwc_out_if out_if();
    aimdwc_cfg_if cfg_if();

    aimd_window_controller_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Model config copy
    logic [WB-1:0]                      cfg_initial = aimdwc_pkg::RST_INITIAL_WINDOW;
    logic [WB-1:0]                      cfg_max     = aimdwc_pkg::RST_MAX_WINDOW;
    logic [WB-1:0]                      cfg_step    = aimdwc_pkg::RST_INCREASE_STEP;
    logic [aimdwc_pkg::FACTOR_BITS-1:0] cfg_factor  = aimdwc_pkg::RST_DECREASE_FACTOR;
    logic [aimdwc_pkg::GAP_BITS-1:0]    cfg_gap     = aimdwc_pkg::RST_MIN_GAP;
    logic                               cfg_off     = 1'b0;

    // Model state
    logic [WB-1:0] win_s       = aimdwc_pkg::RST_INITIAL_WINDOW;
    logic [TB-1:0] last_inc_ms = '0;
    logic          ever_inc    = 1'b0;
    logic [CB-1:0] prev_ins    = '0;
    logic [EB-1:0] prev_err    = '0;
    logic [EB-1:0] err_total   = '0;

    t_window_req         pending_reqs[$];
    aimdwc_pkg::t_result window_expect[$];

    t_window_req held;
    bit          offering   = 1'b0;
    bit          in_quiet   = 1'b0;
    bit          out_quiet  = 1'b0;
    int          gap_left   = 0;
    int          stall_left = 0;
    int          hold_left  = 0;
    logic        hold_kick  = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Stimulus generator time and insert bases
    logic [TB-1:0] clock_ms;
    logic [CB-1:0] ins_base;

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [TB-1:0] rand48();
        return TB'({$urandom, $urandom});
    endfunction

    // Advance the window model by one item and return its result
    function automatic aimdwc_pkg::t_result advance_window(
            input logic [aimdwc_pkg::KIND_BITS-1:0] kind,
            input logic [TB-1:0]                    now,
            input logic [CB-1:0]                    ins);
        aimdwc_pkg::t_result                res;
        logic [aimdwc_pkg::STATUS_BITS-1:0] st;
        logic [WB:0]                        sum;
        logic [2*WB-1:0]                    prod;
        if (kind == aimdwc_pkg::KIND_ERROR) begin
            err_total = err_total + EB'(1);
            st = aimdwc_pkg::ST_ERROR;
        end else if (kind == KIND_UNUSED) begin
            st = aimdwc_pkg::ST_KEPT;
        end else if (cfg_off) begin
            st = aimdwc_pkg::ST_DISABLED;
        end else if (kind == aimdwc_pkg::KIND_INCREASE) begin
            if (ever_inc && (now < TB'(cfg_gap) ||
                             last_inc_ms > now - TB'(cfg_gap))) begin
                st = aimdwc_pkg::ST_RATE_LIMITED;
            end else if (win_s == cfg_max) begin
                st = aimdwc_pkg::ST_AT_MAX;
            end else begin
                sum = {1'b0, win_s} + {1'b0, cfg_step};
                win_s = (sum > {1'b0, cfg_max}) ? cfg_max : sum[WB-1:0];
                last_inc_ms = now;
                ever_inc = 1'b1;
                st = aimdwc_pkg::ST_INCREASED;
            end
        end else begin
            st = aimdwc_pkg::ST_KEPT;
            if (ins > prev_ins && err_total == prev_err) begin
                prod = {{aimdwc_pkg::FACTOR_BITS{1'b0}}, win_s} * {{WB{1'b0}}, cfg_factor};
                win_s = prod[2*WB-1:WB];
                st = aimdwc_pkg::ST_DECREASED;
            end
            prev_ins = ins;
            prev_err = err_total;
        end
        res.window_s    = win_s;
        res.status      = st;
        res.error_total = err_total;
        return res;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Request driver: offer queued items with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            offering = 1'b0;
            gap_left = $urandom_range(0, 14);
        end else begin
            if (offering && in_if.ready) begin
                offering = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    in_quiet = !in_quiet;
                gap_left = in_quiet ? 0 : $urandom_range(0, 14);
            end
            if (!offering) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_reqs.size() != 0) begin
                    held = pending_reqs.pop_front();
                    offering = 1'b1;
                end
            end
            in_if.valid        <= offering;
            in_if.kind         <= held.kind;
            in_if.now_ms       <= held.now_ms;
            in_if.insert_count <= held.insert_count;
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_SPAN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor: check results, then predict newly accepted items
    always @(posedge i_clk) begin
        aimdwc_pkg::t_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (window_expect.size() == 0) begin
                    log_mismatch("result with no item pending");
                end else begin
                    want = window_expect.pop_front();
                    if (out_if.window_s !== want.window_s)
                        log_mismatch($sformatf("window_s got %0d want %0d",
                                               out_if.window_s, want.window_s));
                    if (out_if.status !== want.status)
                        log_mismatch($sformatf("status got %0d want %0d",
                                               out_if.status, want.status));
                    if (out_if.error_total !== want.error_total)
                        log_mismatch($sformatf("error_total got %0d want %0d",
                                               out_if.error_total, want.error_total));
                end
                if ($urandom_range(0, 31) == 0)
                    out_quiet = !out_quiet;
                stall_left = out_quiet ? 0 : $urandom_range(0, 14);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            if (in_if.valid && in_if.ready)
                window_expect.push_back(advance_window(in_if.kind, in_if.now_ms,
                                                       in_if.insert_count));
            out_if.ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_item(input logic [aimdwc_pkg::KIND_BITS-1:0] kind,
                             input logic [TB-1:0] now,
                             input logic [CB-1:0] ins);
        t_window_req r;
        r.kind = kind;
        r.now_ms = now;
        r.insert_count = ins;
        pending_reqs.push_back(r);
    endtask

    // Write one register and mirror it in the model
    task automatic write_reg(input logic [aimdwc_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [DB-1:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            aimdwc_pkg::REG_INITIAL_WINDOW:  cfg_initial = value[WB-1:0];
            aimdwc_pkg::REG_MAX_WINDOW:      cfg_max = value[WB-1:0];
            aimdwc_pkg::REG_INCREASE_STEP:   cfg_step = value[WB-1:0];
            aimdwc_pkg::REG_DECREASE_FACTOR: cfg_factor = value[aimdwc_pkg::FACTOR_BITS-1:0];
            aimdwc_pkg::REG_MIN_GAP:         cfg_gap = value[aimdwc_pkg::GAP_BITS-1:0];
            aimdwc_pkg::REG_ADJUST_DISABLE:  cfg_off = value[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [WB-1:0] initial_win,
                              input logic [WB-1:0] max_win,
                              input logic [WB-1:0] step,
                              input logic [aimdwc_pkg::FACTOR_BITS-1:0] factor,
                              input logic [aimdwc_pkg::GAP_BITS-1:0] gap,
                              input logic off);
        write_reg(aimdwc_pkg::REG_INITIAL_WINDOW, DB'(initial_win));
        write_reg(aimdwc_pkg::REG_MAX_WINDOW, DB'(max_win));
        write_reg(aimdwc_pkg::REG_INCREASE_STEP, DB'(step));
        write_reg(aimdwc_pkg::REG_DECREASE_FACTOR, DB'(factor));
        write_reg(aimdwc_pkg::REG_MIN_GAP, DB'(gap));
        write_reg(aimdwc_pkg::REG_ADJUST_DISABLE, DB'(off));
    endtask

    // Wait until every item is sent and every result is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || in_if.valid || window_expect.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Hold the receiver off while the sender still has items queued
    task automatic long_hold(input int backlog);
        do @(negedge i_clk); while (pending_reqs.size() > backlog);
        @(posedge i_clk);
        hold_kick <= 1'b1;
        @(posedge i_clk);
        hold_kick <= 1'b0;
    endtask

    // Queue random traffic: mostly well-timed increases and growing insert
    // counts, plus early, backwards and stale items and error events
    task automatic queue_traffic(input int count);
        t_window_req r;
        int          pick;
        for (int n = 0; n < count; n++) begin
            r.now_ms = rand48();
            r.insert_count = rand48();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                r.kind = aimdwc_pkg::KIND_INCREASE;
                case ($urandom_range(0, 9))
                    0: clock_ms += TB'($urandom_range(0, cfg_gap));
                    1: clock_ms += TB'({$urandom_range(0, 63), $urandom});
                    2: clock_ms += TB'(cfg_gap);
                    default: clock_ms += TB'(cfg_gap) + TB'($urandom_range(0, 1000));
                endcase
                r.now_ms = clock_ms;
                // backwards time
                if ($urandom_range(0, 9) == 0 && clock_ms > TB'(1000))
                    r.now_ms = clock_ms - TB'($urandom_range(1, 1000));
            end else if (pick < 80) begin
                r.kind = aimdwc_pkg::KIND_DECREASE;
                ins_base += CB'($urandom_range(0, 3));
                r.insert_count = ins_base;
                if ($urandom_range(0, 9) == 0 && ins_base > CB'(8))
                    r.insert_count = ins_base - CB'($urandom_range(1, 8));
            end else if (pick < 95) begin
                r.kind = aimdwc_pkg::KIND_ERROR;
            end else begin
                r.kind = KIND_UNUSED;
            end
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.kind = aimdwc_pkg::KIND_INCREASE;
        in_if.now_ms = '0;
        in_if.insert_count = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = aimdwc_pkg::REG_INITIAL_WINDOW;
        cfg_if.data = '0;
        held = '{aimdwc_pkg::KIND_INCREASE, '0, '0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: first increase, rate limit, backwards time, decrease rules
        set_config(16'd7, 16'd100, 16'd2, 16'd49152, 32'd500, 1'b0);
        push_item(aimdwc_pkg::KIND_INCREASE, 48'd0, rand48());
        push_item(aimdwc_pkg::KIND_INCREASE, 48'd499, rand48());
        push_item(aimdwc_pkg::KIND_INCREASE, 48'd500, rand48());
        push_item(aimdwc_pkg::KIND_INCREASE, 48'd300, rand48());
        push_item(aimdwc_pkg::KIND_DECREASE, rand48(), 48'd10);
        push_item(aimdwc_pkg::KIND_DECREASE, rand48(), 48'd10);
        push_item(aimdwc_pkg::KIND_ERROR, rand48(), rand48());
        push_item(aimdwc_pkg::KIND_DECREASE, rand48(), 48'd11);
        push_item(aimdwc_pkg::KIND_DECREASE, rand48(), 48'd12);
        push_item(KIND_UNUSED, '1, '1);
        push_item(aimdwc_pkg::KIND_DECREASE, rand48(), 48'd0);
        wait_idle();

        // Window above max, then at max
        write_reg(aimdwc_pkg::REG_MAX_WINDOW, 32'd3);
        write_reg(aimdwc_pkg::REG_INCREASE_STEP, 32'hFFFF);
        push_item(aimdwc_pkg::KIND_INCREASE, 48'd2000, rand48());
        push_item(aimdwc_pkg::KIND_INCREASE, 48'd3000, rand48());
        wait_idle();

        // Disabled: requests do nothing, errors still counted
        write_reg(aimdwc_pkg::REG_ADJUST_DISABLE, 32'd1);
        push_item(aimdwc_pkg::KIND_INCREASE, 48'd5000, rand48());
        push_item(aimdwc_pkg::KIND_DECREASE, rand48(), 48'd100);
        push_item(aimdwc_pkg::KIND_ERROR, rand48(), rand48());
        wait_idle();
        write_reg(aimdwc_pkg::REG_ADJUST_DISABLE, 32'd0);
        push_item(aimdwc_pkg::KIND_DECREASE, rand48(), 48'd50);
        push_item(aimdwc_pkg::KIND_DECREASE, rand48(), 48'd51);
        wait_idle();

        // Random phases over several settings
        clock_ms = 48'd3000;
        ins_base = 48'd51;
        set_config(16'd0, 16'd1000, 16'd7, 16'hC000, 32'd100, 1'b0);
        queue_traffic(350);
        long_hold(250);
        wait_idle();

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, 1'b0);
        queue_traffic(250);
        wait_idle();

        set_config(16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 1'b0);
        queue_traffic(100);
        wait_idle();

        set_config(16'd1, 16'd40, 16'd1, 16'd1, 32'hFFFF_FFFF, 1'b0);
        queue_traffic(100);
        wait_idle();

        set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   $urandom, 1'b1);
        queue_traffic(150);
        wait_idle();

        set_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 300)),
                   16'($urandom), $urandom_range(0, 5000), 1'b0);
        queue_traffic(400);
        long_hold(300);
        wait_idle();

        set_config(16'd9, 16'd300, 16'd13, 16'h8000, 32'd1, 1'b0);
        queue_traffic(250);
        wait_idle();

        // Directed: time and insert count at their top values
        set_config(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 32'd0, 1'b0);
        push_item(aimdwc_pkg::KIND_INCREASE, '1, rand48());
        push_item(aimdwc_pkg::KIND_INCREASE, '1, rand48());
        push_item(aimdwc_pkg::KIND_INCREASE, 48'd0, rand48());
        push_item(aimdwc_pkg::KIND_DECREASE, rand48(), '1);
        push_item(aimdwc_pkg::KIND_DECREASE, rand48(), '1);
        wait_idle();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== aimd_window_controller_top.f =====
src/aimdwc_pkg.sv
src/aimdwc_if.sv
src/aimdwc_step.sv
src/aimd_window_controller_top.sv
test/aimd_window_controller_top_test.sv
